// ===== rtl/prds_pkg.sv =====
// Shared constants and types for the pixel replicate dither scaler.
package prds_pkg;

    // Store depths; both are powers of two.
    localparam int LINE_DEPTH  = 4096;
    localparam int NOISE_DEPTH = 4096;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int NOISE_AW    = $clog2(NOISE_DEPTH);
    localparam int WIDTH_W     = $clog2(LINE_DEPTH + 1);

    // Replication limits.
    localparam int MAX_COPIES = 16;
    localparam int COPY_W     = $clog2(MAX_COPIES + 1);
    localparam int K_W        = $clog2(MAX_COPIES);

    // Output queue.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam int PIXEL_MAX = 255;

    // Configuration register layout.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_X_TIMES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DITHER_EN  = 2'd2;

    localparam logic [4:0]  RST_X_TIMES    = 5'd3;
    localparam logic [12:0] RST_LINE_WIDTH = 13'd1024;

    typedef enum logic [1:0] {
        OP_START      = 2'd0,
        OP_LOAD_NOISE = 2'd1,
        OP_PIXEL      = 2'd2,
        OP_REPLAY     = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } t_out_word;

endpackage

// ===== rtl/pixel_replicate_dither_scaler.sv =====
// Pixel replication upscaler with line store, noise store and output queue.
// A pixel or replay word passes the run register, copy stage and output queue before output.
// A pixel or replay word yields 1..16 copies (set by x_times), issued one at a time;
//   the copy sequencer issues one noise store read per copy and waits while the queue lacks credit.
// Start and load-noise words start no run; any word waits for the running copies to issue.
// Reset (synchronous, active low) clears columns, noise pointer, queue and config, not the stores.
module pixel_replicate_dither_scaler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [prds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [11:0]                       i_noise_index,
    input  logic signed [7:0]                 i_noise_value,
    input  logic [7:0]                        i_pixel_in,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_pixel_out,
    output logic                              o_last
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0]  r_x_times;
    logic [12:0] r_line_width;
    logic        r_dither;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_times    <= prds_pkg::RST_X_TIMES;
            r_line_width <= prds_pkg::RST_LINE_WIDTH;
            r_dither     <= 1'b0;
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                prds_pkg::CFG_X_TIMES:    r_x_times    <= i_cfg_data[4:0];
                prds_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data[12:0];
                prds_pkg::CFG_DITHER_EN:  r_dither     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective width and copy count, both clamped into their legal range.
    logic [prds_pkg::WIDTH_W-1:0] eff_width;
    logic [prds_pkg::COPY_W-1:0]  eff_copies;

    always_comb begin
        if (r_line_width == 13'd0) begin
            eff_width = prds_pkg::WIDTH_W'(1);
        end else if (32'(r_line_width) > prds_pkg::LINE_DEPTH) begin
            eff_width = prds_pkg::WIDTH_W'(prds_pkg::LINE_DEPTH);
        end else begin
            eff_width = prds_pkg::WIDTH_W'(r_line_width);
        end
        if (r_x_times == 5'd0) begin
            eff_copies = prds_pkg::COPY_W'(1);
        end else if (32'(r_x_times) > prds_pkg::MAX_COPIES) begin
            eff_copies = prds_pkg::COPY_W'(prds_pkg::MAX_COPIES);
        end else begin
            eff_copies = prds_pkg::COPY_W'(r_x_times);
        end
    end

    // ------------------------------------------------------------------
    // Column and pointer state, copy sequencer
    // ------------------------------------------------------------------
    logic [prds_pkg::LINE_AW-1:0]  r_wcol, n_wcol;
    logic [prds_pkg::LINE_AW-1:0]  r_rcol, n_rcol;
    logic [prds_pkg::NOISE_AW-1:0] r_nptr, n_nptr;

    // The run register holds the word whose copies are being issued.
    logic                  r_run_valid, n_run_valid;
    logic                  r_run_rep, n_run_rep;
    logic [7:0]            r_run_pix, n_run_pix;
    logic [prds_pkg::K_W-1:0] r_run_k, n_run_k;

    logic [7:0] r_line_q;    // line store read data
    logic [7:0] r_noise_q;   // noise store read data

    // Copy stage feeding the dither adder.
    logic       r_p1_valid;
    logic [7:0] r_p1_pix;
    logic       r_p1_last;
    logic       r_p1_dith;

    // Output queue.
    prds_pkg::t_out_word         r_oq [prds_pkg::OQ_DEPTH];
    logic [prds_pkg::OQ_AW-1:0]  r_oq_wr;
    logic [prds_pkg::OQ_AW-1:0]  r_oq_rd;
    logic [prds_pkg::OQ_CW-1:0]  r_oq_cnt;

    logic                 in_acc;
    logic                 run_fire;
    logic                 run_last;
    logic                 credit;
    logic [7:0]           run_pix;
    prds_pkg::t_opcode    op;
    logic [prds_pkg::LINE_AW-1:0]  wcol_use;
    logic [prds_pkg::LINE_AW-1:0]  rcol_use;
    logic [prds_pkg::WIDTH_W-1:0]  wcol_inc;
    logic [prds_pkg::WIDTH_W-1:0]  rcol_inc;
    logic [prds_pkg::NOISE_AW-1:0] noise_idx;
    logic [prds_pkg::NOISE_AW-1:0] nptr_inc;

    assign op = prds_pkg::t_opcode'(i_opcode);

    // Issue a copy only while the queue has room for it and the one in flight.
    assign credit = ((prds_pkg::OQ_CW + 1)'(r_oq_cnt) + (prds_pkg::OQ_CW + 1)'(r_p1_valid))
                    < (prds_pkg::OQ_CW + 1)'(prds_pkg::OQ_DEPTH);
    assign run_fire = r_run_valid && credit;
    assign run_last = (prds_pkg::COPY_W'(r_run_k) + prds_pkg::COPY_W'(1)) == eff_copies;
    assign run_pix  = r_run_rep ? r_line_q : r_run_pix;

    // Every word waits until the current run has issued its last copy, which keeps
    // start and noise loads ordered behind the noise reads of earlier copies.
    assign o_in_stall = r_run_valid && !(run_fire && run_last);
    assign in_acc     = i_in_valid && !o_in_stall;

    // A column at or past the width restarts at zero before use.
    assign wcol_use = (prds_pkg::WIDTH_W'(r_wcol) >= eff_width) ? '0 : r_wcol;
    assign rcol_use = (prds_pkg::WIDTH_W'(r_rcol) >= eff_width) ? '0 : r_rcol;
    assign wcol_inc = prds_pkg::WIDTH_W'(wcol_use) + prds_pkg::WIDTH_W'(1);
    assign rcol_inc = prds_pkg::WIDTH_W'(rcol_use) + prds_pkg::WIDTH_W'(1);

    assign noise_idx = i_noise_index[prds_pkg::NOISE_AW-1:0];
    assign nptr_inc  = (32'(r_nptr) == prds_pkg::NOISE_DEPTH - 1) ? '0
                       : r_nptr + prds_pkg::NOISE_AW'(1);

    always_comb begin
        n_wcol      = r_wcol;
        n_rcol      = r_rcol;
        n_nptr      = r_nptr;
        n_run_valid = r_run_valid;
        n_run_rep   = r_run_rep;
        n_run_pix   = r_run_pix;
        n_run_k     = r_run_k;

        // advance the copy count per issued copy, and the noise pointer too when dither is on
        if (run_fire) begin
            n_run_k = r_run_k + prds_pkg::K_W'(1);
            if (r_dither) begin
                n_nptr = nptr_inc;
            end
            if (run_last) begin
                n_run_valid = 1'b0;
            end
        end

        if (in_acc) begin
            unique case (op)
                prds_pkg::OP_START: begin
                    n_wcol = '0;
                    n_rcol = '0;
                    n_nptr = '0;
                end
                prds_pkg::OP_LOAD_NOISE: begin
                end
                prds_pkg::OP_PIXEL: begin
                    n_wcol      = (wcol_inc >= eff_width) ? '0
                                  : wcol_inc[prds_pkg::LINE_AW-1:0];
                    n_run_valid = 1'b1;
                    n_run_rep   = 1'b0;
                    n_run_pix   = i_pixel_in;
                    n_run_k     = '0;
                end
                prds_pkg::OP_REPLAY: begin
                    n_rcol      = (rcol_inc >= eff_width) ? '0
                                  : rcol_inc[prds_pkg::LINE_AW-1:0];
                    n_run_valid = 1'b1;
                    n_run_rep   = 1'b1;
                    n_run_k     = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcol      <= '0;
            r_rcol      <= '0;
            r_nptr      <= '0;
            r_run_valid <= 1'b0;
        end else begin
            r_wcol      <= n_wcol;
            r_rcol      <= n_rcol;
            r_nptr      <= n_nptr;
            r_run_valid <= n_run_valid;
        end
        r_run_rep <= n_run_rep;
        r_run_pix <= n_run_pix;
        r_run_k   <= n_run_k;
    end

    // ------------------------------------------------------------------
    // Line and noise stores, registered reads
    // ------------------------------------------------------------------
    logic [7:0] line_mem  [prds_pkg::LINE_DEPTH];
    logic [7:0] noise_mem [prds_pkg::NOISE_DEPTH];

    // The line read data holds until the next replay is accepted, which cannot
    // happen before the run that uses it has issued its last copy.
    always_ff @(posedge i_clk) begin
        if (in_acc && (op == prds_pkg::OP_PIXEL)) begin
            line_mem[wcol_use] <= i_pixel_in;
        end
        if (in_acc && (op == prds_pkg::OP_REPLAY)) begin
            r_line_q <= line_mem[rcol_use];
        end
    end

    // A load landing on the edge of the last copy's read returns the old entry,
    // which is the order the words came in.
    always_ff @(posedge i_clk) begin
        if (in_acc && (op == prds_pkg::OP_LOAD_NOISE)) begin
            noise_mem[noise_idx] <= i_noise_value;
        end
        if (run_fire) begin
            r_noise_q <= noise_mem[r_nptr];
        end
    end

    // ------------------------------------------------------------------
    // Dither add and clamp
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= run_fire;
        end
        r_p1_pix  <= run_pix;
        r_p1_last <= run_last;
        r_p1_dith <= r_dither;
    end

    logic signed [9:0] dsum;
    logic [7:0]        p1_out;

    always_comb begin
        dsum = signed'({2'b00, r_p1_pix}) + signed'({{2{r_noise_q[7]}}, r_noise_q});
        if (!r_p1_dith) begin
            p1_out = r_p1_pix;
        end else if (dsum < 10'sd0) begin
            p1_out = 8'd0;
        end else if (dsum > 10'(prds_pkg::PIXEL_MAX)) begin
            p1_out = 8'(prds_pkg::PIXEL_MAX);
        end else begin
            p1_out = dsum[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Output queue; the credit check keeps a push from landing on a full queue
    // ------------------------------------------------------------------
    logic oq_pop;
    logic [prds_pkg::OQ_AW-1:0] oq_wr_inc;
    logic [prds_pkg::OQ_AW-1:0] oq_rd_inc;

    assign oq_pop    = o_out_valid && !i_out_stall;
    assign oq_wr_inc = (32'(r_oq_wr) == prds_pkg::OQ_DEPTH - 1) ? '0
                       : r_oq_wr + prds_pkg::OQ_AW'(1);
    assign oq_rd_inc = (32'(r_oq_rd) == prds_pkg::OQ_DEPTH - 1) ? '0
                       : r_oq_rd + prds_pkg::OQ_AW'(1);

    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            r_oq[r_oq_wr] <= '{pix: p1_out, last: r_p1_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_p1_valid) begin
                r_oq_wr <= oq_wr_inc;
            end
            if (oq_pop) begin
                r_oq_rd <= oq_rd_inc;
            end
            if (r_p1_valid && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + prds_pkg::OQ_CW'(1);
            end else if (!r_p1_valid && oq_pop) begin
                r_oq_cnt <= r_oq_cnt - prds_pkg::OQ_CW'(1);
            end
        end
    end

    assign o_out_valid = (r_oq_cnt != '0);
    assign o_pixel_out = r_oq[r_oq_rd].pix;
    assign o_last      = r_oq[r_oq_rd].last;

`ifndef ASSERT_OFF
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> (32'(r_oq_cnt) < prds_pkg::OQ_DEPTH))
        else $error("output queue push while full");

    a_oq_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_oq_cnt) <= prds_pkg::OQ_DEPTH)
        else $error("output queue count out of range");

    a_run_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ((op == prds_pkg::OP_PIXEL) || (op == prds_pkg::OP_REPLAY)))
        |=> (r_run_valid && (r_run_k == '0)))
        else $error("pixel or replay word did not start a run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run_fire && run_last && !in_acc) |=> !r_run_valid)
        else $error("run continued past its last copy");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the pixel replicate dither scaler: predicts every copy, checks in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Random run length in input words, stall rate in percent, end-of-phase settle time,
    // and the number of cycles with no transfer on either channel that ends the run.
    localparam int RANDOM_WORDS  = 350;
    localparam int STALL_PERCENT = 16;
    localparam int SETTLE_CYCLES = 20;
    localparam int HANG_LIMIT    = 2000;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Configuration write port.
    logic                            cfg_we    = 1'b0;
    logic [prds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [prds_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Input channel.
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode      = prds_pkg::OP_START;
    logic [11:0]       noise_index = '0;
    logic signed [7:0] noise_value = '0;
    logic [7:0]        pixel_in    = '0;

    // Output channel.
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] pixel_out;
    logic       last_out;

    // Run bookkeeping.
    bit no_gaps     = 1'b0;
    int errors      = 0;
    int words_sent  = 0;
    int idle_cycles = 0;

    // Expected output words, oldest first.
    prds_pkg::t_out_word pending_pixels[$];

    // Predictor state: the block's stores, columns and registers as seen from outside.
    logic [7:0]        line_copy  [prds_pkg::LINE_DEPTH];
    bit                line_valid [prds_pkg::LINE_DEPTH];
    logic signed [7:0] noise_copy [prds_pkg::NOISE_DEPTH];
    bit                noise_valid[prds_pkg::NOISE_DEPTH];
    logic [11:0]       wr_col     = '0;
    logic [11:0]       rd_col     = '0;
    logic [11:0]       noise_ptr  = '0;
    logic [4:0]        reg_copies = prds_pkg::RST_X_TIMES;
    logic [12:0]       reg_width  = prds_pkg::RST_LINE_WIDTH;
    logic              reg_dither = 1'b0;

    pixel_replicate_dither_scaler DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_noise_index (noise_index),
        .i_noise_value (noise_value),
        .i_pixel_in    (pixel_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_out   (pixel_out),
        .o_last        (last_out)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Row width as the block applies it: zero acts as one, large values clip to the store.
    function automatic logic [12:0] active_width();
        if (reg_width == 13'd0) return 13'd1;
        if (reg_width > 13'(prds_pkg::LINE_DEPTH)) return 13'(prds_pkg::LINE_DEPTH);
        return reg_width;
    endfunction

    // Copies per pixel: zero acts as one, anything past the maximum saturates.
    function automatic int copy_count();
        if (reg_copies == 5'd0) return 1;
        if (int'(reg_copies) > prds_pkg::MAX_COPIES) return prds_pkg::MAX_COPIES;
        return int'(reg_copies);
    endfunction

    // Advance the predictor by one accepted word and queue the copies it produces.
    task automatic replicate_word(input prds_pkg::t_opcode op, input logic [11:0] idx,
                                  input logic signed [7:0] val, input logic [7:0] pix);
        logic [7:0]          src;
        int                  sum;
        int                  n;
        prds_pkg::t_out_word word;
        src = '0;
        case (op)
            prds_pkg::OP_START: begin
                wr_col    = '0;
                rd_col    = '0;
                noise_ptr = '0;
            end
            prds_pkg::OP_LOAD_NOISE: begin
                noise_copy[idx]  = val;
                noise_valid[idx] = 1'b1;
            end
            prds_pkg::OP_PIXEL: begin
                // A column left past a shrunken width restarts at zero before use.
                if (13'(wr_col) >= active_width()) wr_col = '0;
                line_copy[wr_col]  = pix;
                line_valid[wr_col] = 1'b1;
                src = pix;
                wr_col = wr_col + 12'd1;
                if (13'(wr_col) >= active_width()) wr_col = '0;
            end
            prds_pkg::OP_REPLAY: begin
                if (13'(rd_col) >= active_width()) rd_col = '0;
                src = line_copy[rd_col];
                rd_col = rd_col + 12'd1;
                if (13'(rd_col) >= active_width()) rd_col = '0;
            end
            default: ;
        endcase
        if (op == prds_pkg::OP_PIXEL || op == prds_pkg::OP_REPLAY) begin
            n = copy_count();
            for (int k = 0; k < n; k++) begin
                sum = int'(src);
                if (reg_dither) begin
                    // Add the signed noise entry, clamp to the pixel range, step the
                    // pointer; the 12-bit pointer wraps at the table depth by itself.
                    sum = sum + int'(noise_copy[noise_ptr]);
                    if (sum < 0) sum = 0;
                    if (sum > prds_pkg::PIXEL_MAX) sum = prds_pkg::PIXEL_MAX;
                    noise_ptr = noise_ptr + 12'd1;
                end
                word.pix  = 8'(sum);
                word.last = (k == n - 1);
                pending_pixels.push_back(word);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(0, 99) < STALL_PERCENT);
    endfunction

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic signed [7:0] pick_noise();
        case ($urandom_range(0, 7))
            0:       return 8'h80;
            1:       return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    // Present one word at the falling edge, hold it until accepted, then update the predictor.
    // Fields that the opcode ignores carry random junk so every input bit toggles.
    task automatic send_word(input prds_pkg::t_opcode op, input logic [11:0] idx,
                             input logic signed [7:0] val, input logic [7:0] pix);
        logic [11:0]       idx_d;
        logic signed [7:0] val_d;
        logic [7:0]        pix_d;
        idx_d = (op == prds_pkg::OP_LOAD_NOISE) ? idx : 12'($urandom);
        val_d = (op == prds_pkg::OP_LOAD_NOISE) ? val : 8'($urandom);
        pix_d = (op == prds_pkg::OP_PIXEL) ? pix : 8'($urandom);
        @(negedge clk);
        while (take_gap()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        noise_index <= idx_d;
        noise_value <= val_d;
        pixel_in    <= pix_d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        replicate_word(op, idx, val, pix);
        words_sent++;
    endtask

    // With dither on, load every noise entry the next run will read that was never written.
    task automatic cover_noise();
        logic [11:0] p;
        if (reg_dither) begin
            for (int k = 0; k < copy_count(); k++) begin
                p = noise_ptr + 12'(k);
                if (!noise_valid[p]) send_word(prds_pkg::OP_LOAD_NOISE, p, pick_noise(), '0);
            end
        end
    endtask

    task automatic send_pixel(input logic [7:0] pix);
        cover_noise();
        send_word(prds_pkg::OP_PIXEL, '0, '0, pix);
    endtask

    // Replay the next read column; if that column never held a pixel, send a pixel instead.
    task automatic send_replay();
        logic [11:0] col;
        col = (13'(rd_col) >= active_width()) ? 12'd0 : rd_col;
        if (!line_valid[col]) begin
            send_pixel(pick_pixel());
        end else begin
            cover_noise();
            send_word(prds_pkg::OP_REPLAY, '0, '0, '0);
        end
    endtask

    // Drop valid, wait for every expected copy, then let in-flight no-result words finish.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write: enable high across exactly one rising edge.
    task automatic write_reg(input logic [prds_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= prds_pkg::CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            prds_pkg::CFG_X_TIMES:    reg_copies = 5'(value);
            prds_pkg::CFG_LINE_WIDTH: reg_width  = 13'(value);
            prds_pkg::CFG_DITHER_EN:  reg_dither = 1'(value);
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: three copies, wide row, no dither; pixel extremes and plain replays.
    task automatic test_reset_defaults();
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_replay();
        send_replay();
    endtask

    // Noise at both extremes clamps at both ends; zero copies and zero width act as one.
    task automatic test_noise_clamp();
        send_word(prds_pkg::OP_LOAD_NOISE, 12'd0, 8'h7f, '0);
        send_word(prds_pkg::OP_LOAD_NOISE, 12'd1, 8'h80, '0);
        send_word(prds_pkg::OP_LOAD_NOISE, 12'd2, 8'h00, '0);
        send_word(prds_pkg::OP_LOAD_NOISE, 12'd3, 8'hff, '0);
        send_word(prds_pkg::OP_LOAD_NOISE, 12'd4095, pick_noise(), '0);
        settle();
        write_reg(prds_pkg::CFG_X_TIMES, 0);
        write_reg(prds_pkg::CFG_LINE_WIDTH, 0);
        write_reg(prds_pkg::CFG_DITHER_EN, 1);
        send_word(prds_pkg::OP_START, '0, '0, '0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_replay();
        send_pixel(8'd200);
    endtask

    // Out-of-range replication and width saturate; then the exact maxima.
    task automatic test_range_saturation();
        settle();
        write_reg(prds_pkg::CFG_DITHER_EN, 0);
        write_reg(prds_pkg::CFG_X_TIMES, 31);
        write_reg(prds_pkg::CFG_LINE_WIDTH, 8191);
        send_word(prds_pkg::OP_START, '0, '0, '0);
        send_pixel(8'd17);
        send_replay();
        settle();
        write_reg(prds_pkg::CFG_X_TIMES, 16);
        write_reg(prds_pkg::CFG_LINE_WIDTH, prds_pkg::LINE_DEPTH);
        send_pixel(8'd255);
    endtask

    // Shrink the width mid-row so both columns sit past it and must restart at zero.
    task automatic test_column_shrink();
        settle();
        write_reg(prds_pkg::CFG_X_TIMES, 2);
        write_reg(prds_pkg::CFG_LINE_WIDTH, 8);
        send_word(prds_pkg::OP_START, '0, '0, '0);
        repeat (5) send_pixel(pick_pixel());
        repeat (3) send_replay();
        settle();
        write_reg(prds_pkg::CFG_LINE_WIDTH, 3);
        send_pixel(pick_pixel());
        send_replay();
    endtask

    // Random phases: fresh settings, mostly well-formed frames (row of pixels, then
    // vertical replays), with stray loads, starts and out-of-order words mixed in.
    task automatic test_random_frames();
        int first;
        int phase;
        int ew;
        int vcopies;
        first = words_sent;
        phase = 0;
        while (words_sent - first < RANDOM_WORDS) begin
            // Hold a stretch of phases with no gaps on either side.
            no_gaps = (phase >= 6 && phase < 10);
            settle();
            case ($urandom_range(0, 9))
                0:       write_reg(prds_pkg::CFG_X_TIMES, 0);
                1:       write_reg(prds_pkg::CFG_X_TIMES, prds_pkg::MAX_COPIES);
                2:       write_reg(prds_pkg::CFG_X_TIMES, $urandom_range(17, 31));
                default: write_reg(prds_pkg::CFG_X_TIMES, $urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(prds_pkg::CFG_LINE_WIDTH, 0);
                1:       write_reg(prds_pkg::CFG_LINE_WIDTH, prds_pkg::LINE_DEPTH);
                2:       write_reg(prds_pkg::CFG_LINE_WIDTH,
                                   $urandom_range(prds_pkg::LINE_DEPTH + 1, 8191));
                3:       write_reg(prds_pkg::CFG_LINE_WIDTH, $urandom_range(9, 300));
                default: write_reg(prds_pkg::CFG_LINE_WIDTH, $urandom_range(1, 6));
            endcase
            write_reg(prds_pkg::CFG_DITHER_EN, $urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0) send_word(prds_pkg::OP_START, '0, '0, '0);
            ew = int'(active_width());
            if (ew > 8) begin
                // Too wide for a full row: a partial row, stale replays allowed.
                repeat ($urandom_range(3, 8)) begin
                    if ($urandom_range(0, 1)) send_pixel(pick_pixel());
                    else send_replay();
                end
            end else begin
                vcopies = $urandom_range(1, 3);
                repeat ($urandom_range(1, 2)) begin
                    for (int c = 0; c < ew; c++) begin
                        // Occasionally break the row with a stray word.
                        if ($urandom_range(0, 9) == 0) begin
                            case (prds_pkg::t_opcode'($urandom_range(0, 3)))
                                prds_pkg::OP_START:
                                    send_word(prds_pkg::OP_START, '0, '0, '0);
                                prds_pkg::OP_LOAD_NOISE:
                                    send_word(prds_pkg::OP_LOAD_NOISE, 12'($urandom),
                                              pick_noise(), '0);
                                prds_pkg::OP_PIXEL:
                                    send_pixel(pick_pixel());
                                default:
                                    send_replay();
                            endcase
                        end
                        send_pixel(pick_pixel());
                    end
                    repeat ((vcopies - 1) * ew) send_replay();
                end
            end
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, in-order check, hang watchdog
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        out_stall <= take_gap();
    end

    always @(posedge clk) begin : check_output
        prds_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got pixel %0d last %0b",
                         $time, pixel_out, last_out);
            end else begin
                want = pending_pixels.pop_front();
                if (pixel_out !== want.pix) begin
                    errors++;
                    $display("%0t: pixel mismatch, expected %0d, got %0d",
                             $time, want.pix, pixel_out);
                end
                if (last_out !== want.last) begin
                    errors++;
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, last_out);
                end
            end
        end
    end

    // End the run if no word moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_noise_clamp();
        test_range_saturation();
        test_column_shrink();
        test_random_frames();
        settle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
